[rtl/core/tdlm_pkg.sv]
// Shared widths, constants and codes of the throughput, drop and latency monitor.
package tdlm_pkg;

	localparam int unsigned LATENCY_DEPTH_DEF = 64;

	localparam int unsigned VAL_W     = 32;
	localparam int unsigned TOT_W     = 48;
	localparam int unsigned FRAC_W    = 17;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_W     = TOT_W;

	// shared divider: widest dividend is dropped delta shifted by 16, widest divisor
	// is samples plus dropped deltas
	localparam int unsigned DVD_W  = 64;
	localparam int unsigned DVS_W  = TOT_W + 1;
	localparam int unsigned SCL_W  = 10;
	localparam int unsigned PROD_W = TOT_W + SCL_W;

	localparam logic [SCL_W-1:0]  RATE_SCALE   = 10'd1000;
	localparam logic [TOT_W-1:0]  TOT_MAX      = 48'hFFFF_FFFF_FFFF;
	localparam logic [TOT_W-1:0]  MIN_THR_RST  = 48'd1000;
	localparam logic [FRAC_W-1:0] MAX_DROP_RST = 17'd655;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_THR  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DROP = 1'b1;

	typedef enum logic [2:0] {
		KIND_READ    = 3'd0,
		KIND_WRITE   = 3'd1,
		KIND_SAMPLES = 3'd2,
		KIND_DROPPED = 3'd3,
		KIND_LATENCY = 3'd4,
		KIND_UPDATE  = 3'd5,
		KIND_RESTART = 3'd6
	} kind_t;

endpackage

[rtl/core/throughput_drop_latency_monitor.sv]
// Top level of the throughput, drop and latency monitor: sequencer, counter memory, outputs.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------------
//   in      | in_valid / in_stall | kind, value
//   out     | out_valid/out_stall | rates, drop_fraction, mean_latency, totals, flags
//   cfg     | cfg_we              | cfg_index, cfg_data
//
// Record items (bytes, samples, dropped, latency) take one read of the
// counter memory (or of the oldest window entry), then one write back.
// Restart items are handled in the idle state. An update that does not advance time
// reads only the totals; an update that advances time also reads the snapshots and
// runs up to five divisions, 64 steps each, on the shared divider.
// Reset is asynchronous, needs no clearing pass; counter entries carry valid bits.
// A result waits in the output register while the next record items are taken.
module throughput_drop_latency_monitor
	import tdlm_pkg::*;
#(
	parameter int unsigned LATENCY_DEPTH = LATENCY_DEPTH_DEF
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           kind,
	input  logic [VAL_W-1:0]     value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [TOT_W-1:0]     read_rate,
	output logic [TOT_W-1:0]     write_rate,
	output logic [TOT_W-1:0]     sample_rate,
	output logic [FRAC_W-1:0]    drop_fraction,
	output logic [VAL_W-1:0]     mean_latency,
	output logic [TOT_W-1:0]     total_read,
	output logic [TOT_W-1:0]     total_written,
	output logic [TOT_W-1:0]     total_samples,
	output logic [TOT_W-1:0]     total_dropped,
	output logic                 latency_present,
	output logic                 low_throughput_alert,
	output logic                 high_drop_alert
);

	localparam int unsigned FILL_W = $clog2(LATENCY_DEPTH + 1);
	localparam int unsigned SUM_W  = VAL_W + FILL_W;

	// division jobs: three rates, then drop fraction, then mean latency
	localparam logic [2:0] JOB_DROP = 3'd3;
	localparam logic [2:0] JOB_MEAN = 3'd4;
	// counter memory: totals in entries 0..3, snapshots in 4..7
	localparam logic [2:0] LAST_TOT  = 3'd3;
	localparam logic [2:0] LAST_SNAP = 3'd7;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_ACC  = 8'b0000_0010,
		S_RD   = 8'b0000_0100,
		S_LAND = 8'b0000_1000,
		S_SNAP = 8'b0001_0000,
		S_LOAD = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_EMIT = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [2:0]         ix_q;
	logic [2:0]         job_q;
	logic [2:0]         kind_q;
	logic [VAL_W-1:0]   val_q;
	logic [VAL_W-1:0]   last_time_q;
	logic [VAL_W-1:0]   ms_q;
	logic               upd_q;

	logic [TOT_W-1:0]   cnt_mem [8];
	logic [7:0]         cnt_vld_q;
	logic [TOT_W-1:0]   cnt_rd_s1;
	logic               cnt_rdv_s1;
	logic               rdp_s1;
	logic [2:0]         rdix_s1;
	logic [2:0]         rd_addr;
	logic               wr_en;
	logic [2:0]         wr_addr;
	logic [TOT_W-1:0]   wr_data;
	logic [TOT_W-1:0]   cnt_eff;

	logic [TOT_W-1:0]   tot_q [4];
	logic [TOT_W-1:0]   dlt_q [4];
	logic [TOT_W-1:0]   held_rate_q [3];
	logic [FRAC_W-1:0]  held_drop_q;
	logic [VAL_W-1:0]   held_mean_q;
	logic [TOT_W-1:0]   min_thr_q;
	logic [FRAC_W-1:0]  max_drop_q;

	logic               in_acc;
	logic               div_start;
	logic [DVD_W-1:0]   div_dvd;
	logic [DVS_W-1:0]   div_dvs;
	logic               div_busy;
	logic               div_done;
	logic [DVD_W-1:0]   div_quo;
	logic               job_zero;
	logic               job_store;
	logic [DVD_W-1:0]   job_quo;
	logic [TOT_W-1:0]   rate_sat;
	logic [PROD_W-1:0]  prod;
	logic [DVS_W-1:0]   drop_tot;
	logic               emit_go;
	logic [TOT_W:0]     thr;

	logic               win_push;
	logic               win_clear;
	logic               win_busy;
	logic [SUM_W-1:0]   win_sum;
	logic [FILL_W-1:0]  win_fill;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_thr_q  <= MIN_THR_RST;
			max_drop_q <= MAX_DROP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_THR:  min_thr_q  <= cfg_data;
				REG_MAX_DROP: max_drop_q <= cfg_data[FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- counter memory
	// One read and one write port. The sequencer never reads an entry in the cycle it
	// is written: a record write back finishes before the next item can be taken.
	always_comb begin
		rd_addr = (state_q == S_RD) ? ix_q : {1'b0, kind[1:0]};
		cnt_eff = cnt_rdv_s1 ? cnt_rd_s1 : '0;
		wr_en   = 1'b0;
		wr_addr = {1'b0, kind_q[1:0]};
		wr_data = cnt_eff + TOT_W'(val_q);
		case (state_q)
			S_ACC: begin
				wr_en = (kind_q != KIND_LATENCY);
			end
			S_SNAP: begin
				wr_en   = 1'b1;
				wr_addr = {1'b1, ix_q[1:0]};
				wr_data = tot_q[ix_q[1:0]];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cnt_mem[wr_addr] <= wr_data;
		end
		cnt_rd_s1 <= cnt_mem[rd_addr];
		rdix_s1   <= rd_addr;
	end

	// valid bits stand in for the cleared entries after reset or restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q  <= '0;
			cnt_rdv_s1 <= 1'b0;
			rdp_s1     <= 1'b0;
		end else begin
			cnt_rdv_s1 <= cnt_vld_q[rd_addr];
			rdp_s1     <= (state_q == S_RD);
			if (in_acc && kind == KIND_RESTART) begin
				cnt_vld_q <= '0;
			end else if (wr_en) begin
				cnt_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// land totals first, then turn each snapshot into its delta
	always_ff @(posedge clk) begin
		if (rdp_s1) begin
			if (!rdix_s1[2]) begin
				tot_q[rdix_s1[1:0]] <= cnt_eff;
			end else begin
				dlt_q[rdix_s1[1:0]] <= tot_q[rdix_s1[1:0]] - cnt_eff;
			end
		end
	end

	// ---------------------------------------------------------------- latency window
	assign win_push  = in_acc && (kind == KIND_LATENCY);
	assign win_clear = in_acc && (kind == KIND_RESTART);

	tdlm_win #(
		.DEPTH (LATENCY_DEPTH)
	) u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (win_push),
		.clear  (win_clear),
		.value  (value),
		.busy   (win_busy),
		.sum    (win_sum),
		.fill   (win_fill)
	);

	// ---------------------------------------------------------------- division jobs
	always_comb begin
		prod     = PROD_W'(dlt_q[job_q[1:0]]) * PROD_W'(RATE_SCALE);
		drop_tot = {1'b0, dlt_q[2]} + {1'b0, dlt_q[3]};
		case (job_q)
			JOB_DROP: begin
				div_dvd  = DVD_W'({dlt_q[3], 16'h0000});
				div_dvs  = drop_tot;
				job_zero = (drop_tot == '0);
			end
			JOB_MEAN: begin
				div_dvd  = DVD_W'(win_sum);
				div_dvs  = DVS_W'(win_fill);
				job_zero = (win_fill == '0);
			end
			default: begin
				div_dvd  = DVD_W'(prod);
				div_dvs  = DVS_W'(ms_q);
				job_zero = 1'b0;
			end
		endcase
		div_start = (state_q == S_LOAD) && !job_zero;
		job_store = ((state_q == S_LOAD) && job_zero) || ((state_q == S_DIV) && div_done);
		job_quo   = (state_q == S_DIV) ? div_quo : '0;
		rate_sat  = (job_quo > DVD_W'(TOT_MAX)) ? TOT_MAX : job_quo[TOT_W-1:0];
	end

	tdlm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ix_q        <= '0;
			job_q       <= '0;
			kind_q      <= '0;
			val_q       <= '0;
			last_time_q <= '0;
			ms_q        <= '0;
			upd_q       <= 1'b0;
			held_rate_q <= '{default: '0};
			held_drop_q <= '0;
			held_mean_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						kind_q <= kind;
						val_q  <= value;
						case (kind_t'(kind))
							KIND_READ, KIND_WRITE, KIND_SAMPLES, KIND_DROPPED,
							KIND_LATENCY: begin
								state_q <= S_ACC;
							end
							KIND_UPDATE: begin
								// decide now whether this update recomputes the rates
								ix_q    <= '0;
								upd_q   <= (value > last_time_q);
								ms_q    <= value - last_time_q;
								if (value > last_time_q) begin
									last_time_q <= value;
								end
								state_q <= S_RD;
							end
							KIND_RESTART: begin
								last_time_q <= value;
								held_rate_q <= '{default: '0};
								held_drop_q <= '0;
								held_mean_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_ACC: begin
					state_q <= S_IDLE;
				end
				S_RD: begin
					ix_q <= ix_q + 3'd1;
					if (ix_q == (upd_q ? LAST_SNAP : LAST_TOT)) begin
						state_q <= S_LAND;
					end
				end
				S_LAND: begin
					ix_q    <= '0;
					state_q <= upd_q ? S_SNAP : S_EMIT;
				end
				S_SNAP: begin
					ix_q <= ix_q + 3'd1;
					if (ix_q == LAST_TOT) begin
						job_q   <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD, S_DIV: begin
					if (div_start) begin
						state_q <= S_DIV;
					end else if (job_store) begin
						case (job_q)
							JOB_DROP: held_drop_q <= job_quo[FRAC_W-1:0];
							JOB_MEAN: held_mean_q <= job_quo[VAL_W-1:0];
							default:  held_rate_q[job_q[1:0]] <= rate_sat;
						endcase
						job_q   <= job_q + 3'd1;
						state_q <= (job_q == JOB_MEAN) ? S_EMIT : S_LOAD;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- result register
	assign emit_go = (state_q == S_EMIT) && (!out_valid || !out_stall);
	assign thr     = {1'b0, held_rate_q[0]} + {1'b0, held_rate_q[1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit_go) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// hold the result until taken; load only when the register is free
	always_ff @(posedge clk) begin
		if (emit_go) begin
			read_rate            <= held_rate_q[0];
			write_rate           <= held_rate_q[1];
			sample_rate          <= held_rate_q[2];
			drop_fraction        <= held_drop_q;
			mean_latency         <= held_mean_q;
			total_read           <= tot_q[0];
			total_written        <= tot_q[1];
			total_samples        <= tot_q[2];
			total_dropped        <= tot_q[3];
			latency_present      <= (win_fill != '0);
			low_throughput_alert <= (thr != '0) && (thr < {1'b0, min_thr_q});
			high_drop_alert      <= (held_drop_q > max_drop_q);
		end
	end

	// ---------------------------------------------------------------- assertions
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the division state");

	a_win_idle_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !win_busy)
		else $error("item taken while a window replacement is pending");

	a_load_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> !div_busy && job_q <= JOB_MEAN)
		else $error("division job issued while divider busy or job out of range");

	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_EMIT)
		else $error("result raised outside the emit state");

endmodule

[rtl/core/tdlm_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
module tdlm_div
	import tdlm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the dividend out at the top while the quotient fills in at the bottom
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/core/tdlm_win.sv]
// Sliding latency window: entry memory with running sum, fill count and head pointer.
module tdlm_win
	import tdlm_pkg::*;
#(
	parameter int unsigned DEPTH = LATENCY_DEPTH_DEF,
	localparam int unsigned FILL_W = $clog2(DEPTH + 1),
	localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned SUM_W  = VAL_W + FILL_W
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              clear,
	input  logic [VAL_W-1:0]  value,
	output logic              busy,
	output logic [SUM_W-1:0]  sum,
	output logic [FILL_W-1:0] fill
);

	localparam int unsigned CW = FILL_W + 1;

	logic [VAL_W-1:0]  mem [DEPTH];
	logic [VAL_W-1:0]  rd_s1;
	logic [VAL_W-1:0]  us_q;
	logic [IDX_W-1:0]  head_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  sum_q;
	logic              pend_q;
	logic              full;
	logic [CW-1:0]     wsum;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [VAL_W-1:0]  wdata;

	always_comb begin
		full = (fill_q == FILL_W'(DEPTH));
		wsum = CW'(head_q) + CW'(fill_q);
		if (wsum >= CW'(DEPTH)) begin
			wsum = wsum - CW'(DEPTH);
		end
		if (pend_q) begin
			// overwrite the oldest entry once its old value has been read
			we    = 1'b1;
			waddr = head_q;
			wdata = us_q;
		end else if (push && !full) begin
			we    = 1'b1;
			waddr = wsum[IDX_W-1:0];
			wdata = value;
		end else begin
			we    = 1'b0;
			waddr = head_q;
			wdata = value;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[head_q];
		if (push) begin
			us_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
			pend_q <= 1'b0;
		end else if (clear) begin
			head_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
			pend_q <= 1'b0;
		end else if (pend_q) begin
			sum_q  <= sum_q - SUM_W'(rd_s1) + SUM_W'(us_q);
			head_q <= (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
			pend_q <= 1'b0;
		end else if (push) begin
			if (full) begin
				pend_q <= 1'b1;
			end else begin
				fill_q <= fill_q + FILL_W'(1);
				sum_q  <= sum_q + SUM_W'(value);
			end
		end
	end

	assign busy = pend_q;
	assign sum  = sum_q;
	assign fill = fill_q;

endmodule
